### hdl/assert_macros.svh
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/u8at_pkg.sv
package u8at_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_R     = 8'h52;

    localparam logic [7:0] MASK_E0 = 8'hE0;
    localparam logic [7:0] MASK_F0 = 8'hF0;
    localparam logic [7:0] MASK_F8 = 8'hF8;
    localparam logic [7:0] LEAD2   = 8'hC0;
    localparam logic [7:0] LEAD3   = 8'hE0;
    localparam logic [7:0] LEAD4   = 8'hF0;

    localparam logic [20:0] CP_LSQUO  = 21'h2018;
    localparam logic [20:0] CP_RSQUO  = 21'h2019;
    localparam logic [20:0] CP_SBQUO  = 21'h201A;
    localparam logic [20:0] CP_PRIME  = 21'h2032;
    localparam logic [20:0] CP_LDQUO  = 21'h201C;
    localparam logic [20:0] CP_RDQUO  = 21'h201D;
    localparam logic [20:0] CP_BDQUO  = 21'h201E;
    localparam logic [20:0] CP_DPRIME = 21'h2033;
    localparam logic [20:0] CP_NDASH  = 21'h2013;
    localparam logic [20:0] CP_MDASH  = 21'h2014;
    localparam logic [20:0] CP_MINUS  = 21'h2212;
    localparam logic [20:0] CP_HELLIP = 21'h2026;
    localparam logic [20:0] CP_TRADE  = 21'h2122;
    localparam logic [20:0] CP_COPY   = 21'h00A9;
    localparam logic [20:0] CP_REG    = 21'h00AE;
    localparam logic [20:0] CP_NBSP   = 21'h00A0;
    localparam logic [20:0] CP_FIGSP  = 21'h2007;
    localparam logic [20:0] CP_THINSP = 21'h2009;
    localparam logic [20:0] CP_HAIRSP = 21'h200A;
    localparam logic [20:0] CP_ZWSP   = 21'h200B;
    localparam logic [20:0] CP_ASCMAX = 21'h00007E;
    localparam logic [20:0] CP_CR     = 21'h00000D;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
    } ent_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic ent_t ent_add(ent_t e, logic [7:0] v);
        ent_t r;
        r = e;
        if (r.n < 3'd4)
        begin
            r.bytes[r.n[1:0]] = v;
            r.n = r.n + 3'd1;
        end
        return r;
    endfunction

endpackage

### hdl/u8at_front.sv
module u8at_front
    import u8at_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output ent_t       ent,
    output logic       ent_valid
);

    logic [7:0]  held_bytes_reg [3];
    logic [1:0]  held_count_reg, held_count_next;
    logic [1:0]  bytes_needed_reg, bytes_needed_next;
    logic [20:0] code_accum_reg, code_accum_next;

    logic        hb_we;
    logic [1:0]  hb_wa;

    logic        s_has, s_open;
    logic [7:0]  s_byte;
    logic [1:0]  s_need;
    logic [20:0] s_acc;
    logic [20:0] cp;

    // classification of the byte as a fresh start
    always_comb
    begin
        s_has  = 1'b0;
        s_byte = CH_QMARK;
        s_open = 1'b0;
        s_need = 2'd0;
        s_acc  = '0;
        if (!in_byte[7])
        begin
            if (in_byte != CH_CR)
            begin
                s_has  = 1'b1;
                s_byte = (in_byte >= CH_SPACE || in_byte == CH_LF || in_byte == CH_TAB)
                         ? in_byte : CH_SPACE;
            end
        end
        else if ((in_byte & MASK_E0) == LEAD2)
        begin
            s_open = 1'b1;
            s_need = 2'd1;
            s_acc  = {16'b0, in_byte[4:0]};
        end
        else if ((in_byte & MASK_F0) == LEAD3)
        begin
            s_open = 1'b1;
            s_need = 2'd2;
            s_acc  = {17'b0, in_byte[3:0]};
        end
        else if ((in_byte & MASK_F8) == LEAD4)
        begin
            s_open = 1'b1;
            s_need = 2'd3;
            s_acc  = {18'b0, in_byte[2:0]};
        end
        else
        begin
            s_has = 1'b1;
        end
        if (s_open && end_of_text)
        begin
            s_open = 1'b0;
            s_has  = 1'b1;
            s_byte = CH_QMARK;
        end
    end

    assign cp = {code_accum_reg[14:0], in_byte[5:0]};

    always_comb
    begin
        logic apply_start;
        apply_start       = 1'b0;
        ent               = '0;
        held_count_next   = held_count_reg;
        bytes_needed_next = bytes_needed_reg;
        code_accum_next   = code_accum_reg;
        hb_we             = 1'b0;
        hb_wa             = held_count_reg;

        if (bytes_needed_reg == 2'd0)
        begin
            apply_start = 1'b1;
        end
        else if (end_of_text && bytes_needed_reg > 2'd1)
        begin
            ent               = ent_add(ent, CH_QMARK);
            held_count_next   = 2'd0;
            bytes_needed_next = 2'd0;
            code_accum_next   = '0;
        end
        else if (in_byte[7:6] != 2'b10)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (2'(k) < held_count_reg)
                begin
                    ent = ent_add(ent, CH_QMARK);
                end
            end
            held_count_next   = 2'd0;
            bytes_needed_next = 2'd0;
            code_accum_next   = '0;
            apply_start       = 1'b1;
        end
        else
        begin
            code_accum_next   = cp;
            bytes_needed_next = bytes_needed_reg - 2'd1;
            if (bytes_needed_reg == 2'd1)
            begin
                case (cp)
                    CP_LSQUO, CP_RSQUO, CP_SBQUO, CP_PRIME:
                        ent = ent_add(ent, CH_APOS);
                    CP_LDQUO, CP_RDQUO, CP_BDQUO, CP_DPRIME:
                        ent = ent_add(ent, CH_QUOTE);
                    CP_NDASH, CP_MDASH, CP_MINUS:
                        ent = ent_add(ent, CH_DASH);
                    CP_HELLIP:
                    begin
                        ent = ent_add(ent, CH_DOT);
                        ent = ent_add(ent, CH_DOT);
                        ent = ent_add(ent, CH_DOT);
                    end
                    CP_TRADE:
                    begin
                        ent = ent_add(ent, CH_LPAR);
                        ent = ent_add(ent, CH_T);
                        ent = ent_add(ent, CH_M);
                        ent = ent_add(ent, CH_RPAR);
                    end
                    CP_COPY:
                    begin
                        ent = ent_add(ent, CH_LPAR);
                        ent = ent_add(ent, CH_C);
                        ent = ent_add(ent, CH_RPAR);
                    end
                    CP_REG:
                    begin
                        ent = ent_add(ent, CH_LPAR);
                        ent = ent_add(ent, CH_R);
                        ent = ent_add(ent, CH_RPAR);
                    end
                    CP_NBSP, CP_FIGSP, CP_THINSP, CP_HAIRSP, CP_ZWSP:
                        ent = ent_add(ent, CH_SPACE);
                    default:
                    begin
                        if (cp <= CP_ASCMAX)
                        begin
                            if (cp != CP_CR)
                            begin
                                ent = ent_add(ent, cp[7:0]);
                            end
                        end
                        else
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                if (2'(k) < held_count_reg)
                                begin
                                    ent = ent_add(ent, held_bytes_reg[k]);
                                end
                            end
                            ent = ent_add(ent, in_byte);
                        end
                    end
                endcase
                held_count_next   = 2'd0;
                bytes_needed_next = 2'd0;
                code_accum_next   = '0;
            end
            else if (held_count_reg < 2'd3)
            begin
                hb_we           = 1'b1;
                held_count_next = held_count_reg + 2'd1;
            end
            else
            begin
                held_count_next   = 2'd0;
                bytes_needed_next = 2'd0;
                code_accum_next   = '0;
            end
        end

        if (apply_start)
        begin
            if (s_has)
            begin
                ent = ent_add(ent, s_byte);
            end
            if (s_open)
            begin
                hb_we             = 1'b1;
                hb_wa             = 2'd0;
                held_count_next   = 2'd1;
                bytes_needed_next = s_need;
                code_accum_next   = s_acc;
            end
        end

        if (end_of_text)
        begin
            held_count_next   = 2'd0;
            bytes_needed_next = 2'd0;
            code_accum_next   = '0;
        end
    end

    assign ent_valid = accept && (ent.n != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg   <= 2'd0;
            bytes_needed_reg <= 2'd0;
            code_accum_reg   <= '0;
        end
        else if (accept)
        begin
            held_count_reg   <= held_count_next;
            bytes_needed_reg <= bytes_needed_next;
            code_accum_reg   <= code_accum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hb_we)
        begin
            held_bytes_reg[hb_wa] <= in_byte;
        end
    end

endmodule

### hdl/u8at_queue.sv
module u8at_queue
    import u8at_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  ent_t    wr_ent,
    input  logic    rd,
    output ent_t    head,
    output q_stat_t stat
);

    ent_t             mem_reg [QDEPTH];
    logic [QAW-1:0]   wp_reg, rp_reg;
    logic [QAW:0]     cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign head       = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + (QAW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wp_reg <= wp_reg + QAW'(1);
            end
            if (do_rd)
            begin
                rp_reg <= rp_reg + QAW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_ent;
        end
    end

endmodule

### hdl/u8at_back.sv
module u8at_back
    import u8at_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ent_t       head,
    input  q_stat_t    stat,
    input  logic       pop,
    output logic       q_rd,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       empty
);

    logic [1:0] idx_reg, idx_next;
    logic       take;

    assign empty    = stat.empty;
    assign out_byte = head.bytes[idx_reg];
    assign run_last = ({1'b0, idx_reg} == (head.n - 3'd1));
    assign take     = pop && !stat.empty;
    assign q_rd     = take && run_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = run_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

### hdl/utf8_ascii_transliterator.sv
// Byte-stream UTF-8 to display ASCII cleaner. One byte is taken per cycle while full is low;
// its results (zero to four bytes, the last marked by run_last) go as one entry, if any, into a
// four-entry queue, and the result side hands out one byte per cycle from the oldest entry
// while pop is high. A byte that expands to several bytes holds the result side until all
// are handed out, so plain text sustains one input byte per cycle and expansions slow the
// input; the queue depth sets how far the input side runs ahead. A result first shows in
// the cycle after its byte is taken.
module utf8_ascii_transliterator
    import u8at_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last
);

    ent_t    f_ent, q_head;
    logic    f_valid, q_rd, accept;
    q_stat_t q_stat;

    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    u8at_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .end_of_text(end_of_text),
        .ent        (f_ent),
        .ent_valid  (f_valid)
    );

    u8at_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (f_valid),
        .wr_ent(f_ent),
        .rd    (q_rd),
        .head  (q_head),
        .stat  (q_stat)
    );

    u8at_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .stat    (q_stat),
        .pop     (pop),
        .q_rd    (q_rd),
        .out_byte(out_byte),
        .run_last(run_last),
        .empty   (empty)
    );

endmodule

### hdl/u8at_checker.sv
`include "assert_macros.svh"

module u8at_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       run_last
);

    logic mid_pop;

    assign mid_pop = pop && !empty && !run_last;

    // a waiting result holds until taken
    `AST_NEXT(a_hold, !empty && !pop, $stable(out_byte) && $stable(run_last))
    // nothing appears without an accepted item
    `AST_NEXT(a_no_invent, empty && !(push && !full), empty)
    // no item yields more than four bytes
    `AST_NEXT(a_max_run, mid_pop ##1 mid_pop ##1 mid_pop, !mid_pop)
    // a full queue always has something to hand out
    `AST_IMPL(a_full_nonempty, full, !empty)

endmodule

bind utf8_ascii_transliterator u8at_checker u_chk (.*);
